// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros for the matrix product block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");

`endif

// ===== rtl/mm4_pkg.sv =====
// ----------------------------------------------------------------------------
// mm4_pkg
// constants, types and helpers shared by the matrix product block
// ----------------------------------------------------------------------------
package mm4_pkg;

    localparam int DIM       = 4;
    localparam int FRAC_BITS = 16;
    localparam int CELLS     = DIM * DIM;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int K_W       = $clog2(DIM);
    localparam int IDX_W     = 2;
    localparam int ACT_W     = 2;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = PROD_W + $clog2(DIM);

    localparam logic [ACT_W-1:0] ACT_LOAD_LEFT  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD_RIGHT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COMPUTE    = 2'd2;

    // control travelling alongside one read of the two stores
    typedef struct packed {
        logic             vld;
        logic             first;
        logic             last;
        logic             run_last;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_mac_ctl;

    function automatic logic [ADDR_W-1:0] cell_addr(input int unsigned row,
                                                    input int unsigned col);
        return ADDR_W'(row * DIM + col);
    endfunction

    // drop fraction bits (floor) and clamp to a signed 32 bit word
    function automatic logic [DATA_W-1:0] shift_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] sh;
        logic [ACC_W-DATA_W:0]   top;
        sh  = acc >>> FRAC_BITS;
        top = sh[ACC_W-1:DATA_W-1];
        if ((&top) || !(|top)) begin
            return sh[DATA_W-1:0];
        end else if (sh[ACC_W-1]) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

endpackage

// ===== rtl/mm4_if.sv =====
// ----------------------------------------------------------------------------
// mm4_if
// valid/ready channels for command beats and product beats
// ----------------------------------------------------------------------------
interface mm4_in_if;
    import mm4_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [ACT_W-1:0]         action;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [DATA_W-1:0] element_value;

    modport source (output valid, action, row_index, col_index, element_value,
                    input ready);
    modport sink   (input valid, action, row_index, col_index, element_value,
                    output ready);
endinterface

interface mm4_out_if;
    import mm4_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic signed [DATA_W-1:0] product_value;
    logic                     last_of_run;

    modport source (output valid, out_row, out_col, product_value, last_of_run,
                    input ready);
    modport sink   (input valid, out_row, out_col, product_value, last_of_run,
                    output ready);
endinterface

// ===== rtl/mm4_store.sv =====
// ----------------------------------------------------------------------------
// mm4_store
// left and right element memories, one write port, registered reads
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mm4_store (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr_en,
    input  logic                              i_wr_right,
    input  logic [mm4_pkg::ADDR_W-1:0]        i_wr_addr,
    input  logic signed [mm4_pkg::DATA_W-1:0] i_wr_data,
    input  logic                              i_rd_en,
    input  logic [mm4_pkg::ADDR_W-1:0]        i_rd_left_addr,
    input  logic [mm4_pkg::ADDR_W-1:0]        i_rd_right_addr,
    output logic signed [mm4_pkg::DATA_W-1:0] o_left_data,
    output logic signed [mm4_pkg::DATA_W-1:0] o_right_data
);
    import mm4_pkg::*;

    logic signed [DATA_W-1:0] r_left_mem  [CELLS];
    logic signed [DATA_W-1:0] r_right_mem [CELLS];
    logic [CELLS-1:0]         r_left_vld;
    logic [CELLS-1:0]         r_right_vld;
    logic signed [DATA_W-1:0] r_left_rd;
    logic signed [DATA_W-1:0] r_right_rd;
    logic                     r_left_rd_vld;
    logic                     r_right_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en && !i_wr_right) begin
            r_left_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_wr_en && i_wr_right) begin
            r_right_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_left_rd  <= r_left_mem[i_rd_left_addr];
            r_right_rd <= r_right_mem[i_rd_right_addr];
        end
    end

    // written flags, an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_vld     <= '0;
            r_right_vld    <= '0;
            r_left_rd_vld  <= 1'b0;
            r_right_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en && !i_wr_right) begin
                r_left_vld[i_wr_addr] <= 1'b1;
            end
            if (i_wr_en && i_wr_right) begin
                r_right_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_left_rd_vld  <= r_left_vld[i_rd_left_addr];
                r_right_rd_vld <= r_right_vld[i_rd_right_addr];
            end
        end
    end

    assign o_left_data  = r_left_rd_vld  ? r_left_rd  : '0;
    assign o_right_data = r_right_rd_vld ? r_right_rd : '0;

    // loads only land while no product run is reading
    `ASSERT_NEVER(a_no_wr_during_rd, i_clk, i_rst_n, i_wr_en && i_rd_en)

endmodule

// ===== rtl/mm4_seq.sv =====
// ----------------------------------------------------------------------------
// mm4_seq
// walks the product elements and issues one pair of reads per term
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mm4_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_beat,
    output logic                       o_idle,
    output logic                       o_rd_en,
    output logic [mm4_pkg::ADDR_W-1:0] o_left_addr,
    output logic [mm4_pkg::ADDR_W-1:0] o_right_addr,
    output mm4_pkg::t_mac_ctl          o_ctl
);
    import mm4_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;

    localparam logic [K_W-1:0] K_LAST = K_W'(DIM - 1);

    logic [1:0]     r_state, n_state;
    logic [K_W-1:0] r_i, n_i;
    logic [K_W-1:0] r_j, n_j;
    logic [K_W-1:0] r_k, n_k;
    logic           run_last;

    assign run_last = (r_i == K_LAST) && (r_j == K_LAST);

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_ISSUE;
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                end
            end
            S_ISSUE: begin
                if (r_k == K_LAST) begin
                    n_state = S_WAIT;
                    n_k     = '0;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_WAIT: begin
                if (i_beat) begin
                    if (run_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_ISSUE;
                        if (r_j == K_LAST) begin
                            n_j = '0;
                            n_i = r_i + 1'b1;
                        end else begin
                            n_j = r_j + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    assign o_idle       = (r_state == S_IDLE);
    assign o_rd_en      = (r_state == S_ISSUE);
    assign o_left_addr  = cell_addr(32'(r_i), 32'(r_k));
    assign o_right_addr = cell_addr(32'(r_k), 32'(r_j));

    always_comb begin
        o_ctl          = '0;
        o_ctl.vld      = (r_state == S_ISSUE);
        o_ctl.first    = (r_k == '0);
        o_ctl.last     = (r_k == K_LAST);
        o_ctl.run_last = run_last;
        o_ctl.row      = IDX_W'(r_i);
        o_ctl.col      = IDX_W'(r_j);
    end

    // a product beat only ever answers an element we are waiting on
    `ASSERT_CLK(a_beat_when_waiting, i_clk, i_rst_n, i_beat |-> (r_state == S_WAIT))
    // every element issues its terms back to back from the first
    `ASSERT_CLK(a_terms_contiguous, i_clk, i_rst_n,
        (o_ctl.vld && !o_ctl.first) |-> $past(o_ctl.vld))

endmodule

// ===== rtl/mm4_mac.sv =====
// ----------------------------------------------------------------------------
// mm4_mac
// multiply, exact accumulate, shift, clamp and product output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mm4_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mm4_pkg::t_mac_ctl                 i_ctl,
    input  logic signed [mm4_pkg::DATA_W-1:0] i_left_data,
    input  logic signed [mm4_pkg::DATA_W-1:0] i_right_data,
    output logic                              o_beat,
    mm4_out_if.source                         o_out
);
    import mm4_pkg::*;

    t_mac_ctl                 r_s1_ctl;
    t_mac_ctl                 r_s2_ctl;
    t_mac_ctl                 r_s3_ctl;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  prod_ext;
    logic                     acc_done;
    logic                     r_out_vld;
    logic [IDX_W-1:0]         r_out_row;
    logic [IDX_W-1:0]         r_out_col;
    logic [DATA_W-1:0]        r_out_val;
    logic                     r_out_last;

    assign prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign acc_done = r_s3_ctl.vld && r_s3_ctl.last;
    assign o_beat   = r_out_vld && o_out.ready;

    // control pipeline, lined up with read data, product and sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
            r_s2_ctl <= '0;
            r_s3_ctl <= '0;
        end else begin
            r_s1_ctl <= i_ctl;
            r_s2_ctl <= r_s1_ctl;
            r_s3_ctl <= r_s2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_ctl.vld) begin
            r_prod <= i_left_data * i_right_data;
        end
        if (r_s2_ctl.vld) begin
            r_acc <= r_s2_ctl.first ? prod_ext : r_acc + prod_ext;
        end
        if (acc_done) begin
            r_out_row  <= r_s3_ctl.row;
            r_out_col  <= r_s3_ctl.col;
            r_out_val  <= shift_sat(r_acc);
            r_out_last <= r_s3_ctl.run_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (acc_done) begin
            r_out_vld <= 1'b1;
        end else if (o_beat) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.out_row       = r_out_row;
    assign o_out.out_col       = r_out_col;
    assign o_out.product_value = r_out_val;
    assign o_out.last_of_run   = r_out_last;

    // a finished sum never overwrites a product still waiting
    `ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, acc_done && r_out_vld)

endmodule

// ===== rtl/matrix4_multiply.sv =====
// load beats: one per cycle while no product run is in progress, written to the stores at the accepting edge
// compute beat: starts a run of 16 product beats; each element takes 4 term reads
//   on the single read port of each store, then multiply, sum and clamp stages,
//   and the next element's reads wait until its product beat is taken
// first product beat follows the store read, product, sum and output registers
// reset: synchronous, active low; both stores read as zero until written
// ----------------------------------------------------------------------------
// matrix4_multiply
// 4x4 signed Q16.16 matrix product built around two element memories
// ----------------------------------------------------------------------------
module matrix4_multiply (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mm4_in_if.sink    i_in,
    mm4_out_if.source o_out
);
    import mm4_pkg::*;

    logic                     in_beat;
    logic                     idle;
    logic                     start;
    logic                     wr_en;
    logic                     wr_right;
    logic                     in_range;
    logic [ADDR_W-1:0]        wr_addr;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_left_addr;
    logic [ADDR_W-1:0]        rd_right_addr;
    logic signed [DATA_W-1:0] left_data;
    logic signed [DATA_W-1:0] right_data;
    t_mac_ctl                 ctl;
    logic                     out_beat;

    // command beats are taken only between product runs
    assign i_in.ready = idle;
    assign in_beat    = i_in.valid && i_in.ready;

    // element loads outside the matrix are dropped
    assign in_range = (32'(i_in.row_index) < DIM) && (32'(i_in.col_index) < DIM);
    assign wr_addr  = cell_addr(32'(i_in.row_index), 32'(i_in.col_index));

    // decode the command beat; the spare code does nothing
    always_comb begin
        wr_en    = 1'b0;
        wr_right = 1'b0;
        start    = 1'b0;
        unique case (i_in.action)
            ACT_LOAD_LEFT: begin
                wr_en = in_beat && in_range;
            end
            ACT_LOAD_RIGHT: begin
                wr_en    = in_beat && in_range;
                wr_right = 1'b1;
            end
            ACT_COMPUTE: begin
                start = in_beat;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // left and right element memories
    mm4_store u_store (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_wr_en         (wr_en),
        .i_wr_right      (wr_right),
        .i_wr_addr       (wr_addr),
        .i_wr_data       (i_in.element_value),
        .i_rd_en         (rd_en),
        .i_rd_left_addr  (rd_left_addr),
        .i_rd_right_addr (rd_right_addr),
        .o_left_data     (left_data),
        .o_right_data    (right_data)
    );

    // element and term walker, holds each element until its beat is taken
    mm4_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_beat       (out_beat),
        .o_idle       (idle),
        .o_rd_en      (rd_en),
        .o_left_addr  (rd_left_addr),
        .o_right_addr (rd_right_addr),
        .o_ctl        (ctl)
    );

    // multiply-accumulate datapath and product output register
    mm4_mac u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_left_data  (left_data),
        .i_right_data (right_data),
        .o_beat       (out_beat),
        .o_out        (o_out)
    );

endmodule

// ===== tb/sv/tb_matrix4_multiply.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_matrix4_multiply
// self-checking bench for the 4x4 Q16.16 matrix product: command beats load
// the two element stores and request runs, every product beat is compared
// with an exact 70 bit dot product that is floored and clamped in the bench
// ----------------------------------------------------------------------------
module tb_matrix4_multiply;
    import mm4_pkg::*;

    // action code that the block must ignore
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 24;      // slack after the last expected product
    localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
    localparam int CYCLE_LIMIT  = 400000;  // watchdog
    localparam int PHASE_ITEMS  = 80;      // counted beats per random phase

    // one command beat
    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

    // one product beat
    typedef struct packed {
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_prod;

    // ------------------------------------------------------------------------
    // product scoreboard: mirrors both stores and queues the expected run
    // ------------------------------------------------------------------------
    class product_board;
        logic signed [DATA_W-1:0] left_cells  [CELLS];
        logic signed [DATA_W-1:0] right_cells [CELLS];
        t_prod                    queued_products [$];
        int unsigned              errors;

        function new();
            for (int n = 0; n < CELLS; n++) begin
                left_cells[n]  = '0;
                right_cells[n] = '0;
            end
            errors = 0;
        endfunction

        // exact sum of four products, floor by the fraction bits, clamp to 32 bits
        function logic signed [DATA_W-1:0] dot_element(int i, int j);
            localparam logic signed [69:0] SAT_HI = 70'sd2147483647;
            localparam logic signed [69:0] SAT_LO = -70'sd2147483648;
            logic signed [69:0]       sum;
            logic signed [69:0]       sh;
            logic signed [DATA_W-1:0] a;
            logic signed [DATA_W-1:0] b;
            sum = '0;
            for (int k = 0; k < DIM; k++) begin
                a   = left_cells[i * DIM + k];
                b   = right_cells[k * DIM + j];
                sum = sum + a * b;
            end
            sh = sum >>> FRAC_BITS;
            if (sh > SAT_HI) begin
                return 32'h7FFF_FFFF;
            end else if (sh < SAT_LO) begin
                return 32'h8000_0000;
            end
            return sh[DATA_W-1:0];
        endfunction

        // an accepted command beat: update a store or queue a full run
        function void note_command(t_cmd c);
            t_prod p;
            case (c.action)
                ACT_LOAD_LEFT:  left_cells[c.row * DIM + c.col]  = c.value;
                ACT_LOAD_RIGHT: right_cells[c.row * DIM + c.col] = c.value;
                ACT_COMPUTE: begin
                    for (int i = 0; i < DIM; i++) begin
                        for (int j = 0; j < DIM; j++) begin
                            p.row   = IDX_W'(i);
                            p.col   = IDX_W'(j);
                            p.value = dot_element(i, j);
                            p.last  = (i == DIM - 1) && (j == DIM - 1);
                            queued_products.push_back(p);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        // an accepted product beat against the oldest expectation
        function void check_product(t_prod got);
            t_prod want;
            if (queued_products.size() == 0) begin
                $display("%0t: unexpected product beat row %0d col %0d value %h last %b",
                         $time, got.row, got.col, got.value, got.last);
                errors++;
                return;
            end
            want = queued_products.pop_front();
            if (got.row !== want.row) begin
                $display("%0t: out_row mismatch expected %0d actual %0d",
                         $time, want.row, got.row);
                errors++;
            end
            if (got.col !== want.col) begin
                $display("%0t: out_col mismatch expected %0d actual %0d",
                         $time, want.col, got.col);
                errors++;
            end
            if (got.value !== want.value) begin
                $display("%0t: product_value mismatch at (%0d,%0d) expected %h actual %h",
                         $time, want.row, want.col, want.value, got.value);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last_of_run mismatch at (%0d,%0d) expected %b actual %b",
                         $time, want.row, want.col, want.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return queued_products.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;

    mm4_in_if  cmd_if ();
    mm4_out_if prod_if ();

    matrix4_multiply DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (cmd_if),
        .o_out   (prod_if)
    );

    product_board board;

    int send_idle_pct;     // chance in a hundred that the sender idles instead of offering
    int recv_idle_pct;     // same for the receiver
    int hold_seq;          // bumped by the stimulus to request a hold-off
    int cycle_count;

    // 2 ns period
    initial clk = 1'b0;
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // every input known from time zero
    initial begin
        rst_n                <= 1'b0;
        cmd_if.valid         <= 1'b0;
        cmd_if.action        <= ACT_LOAD_LEFT;
        cmd_if.row_index     <= '0;
        cmd_if.col_index     <= '0;
        cmd_if.element_value <= '0;
        prod_if.ready        <= 1'b0;
    end

    // watchdog
    initial cycle_count = 0;
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("matrix4_multiply regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // product side: take beats, idle at random, honour hold-off requests
    // ------------------------------------------------------------------------
    initial begin : product_sink
        t_prod got;
        int    seen_seq;
        int    hold_left;
        seen_seq  = 0;
        hold_left = 0;
        forever begin
            @(posedge clk);
            // values seen here are those before the edge
            if (rst_n && prod_if.valid && prod_if.ready) begin
                got.row   = prod_if.out_row;
                got.col   = prod_if.out_col;
                got.value = prod_if.product_value;
                got.last  = prod_if.last_of_run;
                board.check_product(got);
            end
            if (hold_seq != seen_seq) begin
                seen_seq  = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                prod_if.ready <= 1'b0;
            end else begin
                prod_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // command side helpers
    // ------------------------------------------------------------------------
    function automatic t_cmd make_cmd(logic [ACT_W-1:0] act, int row, int col,
                                      logic [DATA_W-1:0] value);
        t_cmd c;
        c.action = act;
        c.row    = IDX_W'(row);
        c.col    = IDX_W'(col);
        c.value  = value;
        return c;
    endfunction

    // mostly modest Q16.16 values so sums stay in range, with extremes mixed in
    function automatic logic [DATA_W-1:0] rand_element();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return ($urandom_range(1)) ? 32'h0000_0001 : 32'hFFFF_FFFF;
            3, 4:    return $urandom;
            default: return DATA_W'(int'($urandom_range(524287)) - 262144);
        endcase
    endfunction

    // offer one beat, idling first at random, and return once it is taken;
    // valid stays high on return so back-to-back beats need no second write
    task automatic send_command(t_cmd c);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid         <= 1'b1;
        cmd_if.action        <= c.action;
        cmd_if.row_index     <= c.row;
        cmd_if.col_index     <= c.col;
        cmd_if.element_value <= c.value;
        do @(posedge clk); while (!cmd_if.ready);
        board.note_command(c);
    endtask

    // stop offering and let every queued product come out
    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // random traffic: load runs with random content, computes and some noise
    task automatic random_phase(int counted);
        int   sent;
        int   pick;
        t_cmd c;
        sent = 0;
        while (sent < counted) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                // ignored code, not counted
                c = make_cmd(ACT_UNUSED, $urandom_range(3), $urandom_range(3), $urandom);
            end else begin
                if (pick < 13) begin
                    c = make_cmd(ACT_COMPUTE, $urandom_range(3), $urandom_range(3),
                                 $urandom);
                end else if (pick < 56) begin
                    c = make_cmd(ACT_LOAD_LEFT, $urandom_range(3), $urandom_range(3),
                                 rand_element());
                end else begin
                    c = make_cmd(ACT_LOAD_RIGHT, $urandom_range(3), $urandom_range(3),
                                 rand_element());
                end
                sent++;
            end
            send_command(c);
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_cmd directed [$];
        board         = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_seq      = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // stores cleared by reset: an all-zero run
        directed.push_back(make_cmd(ACT_COMPUTE, 0, 0, 32'h0));
        // unused code with every field at its top, must change nothing
        directed.push_back(make_cmd(ACT_UNUSED, 3, 3, 32'hFFFF_FFFF));
        // one lsb negative times one lsb: floors to minus one lsb
        directed.push_back(make_cmd(ACT_LOAD_LEFT,  0, 0, 32'hFFFF_FFFF));
        directed.push_back(make_cmd(ACT_LOAD_RIGHT, 0, 0, 32'h0000_0001));
        // max times max saturates high
        directed.push_back(make_cmd(ACT_LOAD_LEFT,  3, 3, 32'h7FFF_FFFF));
        directed.push_back(make_cmd(ACT_LOAD_RIGHT, 3, 3, 32'h7FFF_FFFF));
        // most negative times max saturates low, times 1.0 stays exact
        directed.push_back(make_cmd(ACT_LOAD_LEFT,  1, 2, 32'h8000_0000));
        directed.push_back(make_cmd(ACT_LOAD_RIGHT, 2, 1, 32'h7FFF_FFFF));
        directed.push_back(make_cmd(ACT_LOAD_RIGHT, 2, 0, 32'h0001_0000));
        directed.push_back(make_cmd(ACT_COMPUTE, 3, 3, 32'h0));
        // four most-negative squares: sum needs more than 64 bits
        for (int k = 0; k < DIM; k++) begin
            directed.push_back(make_cmd(ACT_LOAD_LEFT,  2, k, 32'h8000_0000));
            directed.push_back(make_cmd(ACT_LOAD_RIGHT, k, 2, 32'h8000_0000));
        end
        directed.push_back(make_cmd(ACT_COMPUTE, 0, 0, 32'h0));
        foreach (directed[n]) send_command(directed[n]);
        wait_drained();

        // sender idles often, receiver more often
        send_idle_pct = 26;
        recv_idle_pct = 86;
        random_phase(PHASE_ITEMS);
        wait_drained();

        // roles swapped
        send_idle_pct = 86;
        recv_idle_pct = 26;
        random_phase(PHASE_ITEMS);
        wait_drained();

        // long hold-off on the product side while computes keep coming,
        // so the block backs up and stalls the command side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_seq      = hold_seq + 1;
        for (int n = 0; n < 4; n++) begin
            send_command(make_cmd(ACT_LOAD_LEFT, $urandom_range(3), $urandom_range(3),
                                  rand_element()));
            send_command(make_cmd(ACT_LOAD_RIGHT, $urandom_range(3), $urandom_range(3),
                                  rand_element()));
            send_command(make_cmd(ACT_COMPUTE, 0, 0, 32'h0));
        end
        wait_drained();

        // no idling on either side
        random_phase(PHASE_ITEMS);
        wait_drained();

        if (board.errors == 0 && board.pending() == 0) begin
            $display("matrix4_multiply regression: pass");
        end else begin
            $display("matrix4_multiply regression: fail");
        end
        $finish;
    end

endmodule
